// ----- rtl/core/ncdf_pkg.sv -----
// Shared constants and types for the near-circle duplicate filter.
`timescale 1ns / 1ps

package ncdf_pkg;

   localparam int MAX_KEPT     = 64;
   localparam int COORD_W      = 16;
   localparam int KEPT_INDEX_W = 7;
   localparam int COUNT_W      = $clog2(MAX_KEPT + 1);
   localparam int ADDR_W       = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;

   typedef logic [COORD_W-1:0] coord_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
      coord_type radius;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

// ----- rtl/core/ncdf_if.sv -----
// Request and response channel interfaces for the near-circle duplicate filter.
`timescale 1ns / 1ps

interface ncdf_req_if;
   logic                valid;
   logic                ready;
   ncdf_pkg::coord_type center_x;
   ncdf_pkg::coord_type center_y;
   ncdf_pkg::coord_type radius;
   logic                starts_list;

   modport source (output valid, center_x, center_y, radius, starts_list, input ready);
   modport sink   (input valid, center_x, center_y, radius, starts_list, output ready);
endinterface

interface ncdf_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                kept;
   logic [ncdf_pkg::KEPT_INDEX_W-1:0]   kept_index;
   logic                                table_full;

   modport source (output valid, kept, kept_index, table_full, input ready);
   modport sink   (input valid, kept, kept_index, table_full, output ready);
endinterface

// ----- rtl/core/ncdf_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module ncdf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/ncdf_cmp.sv -----
// Shared proximity compare unit: tests one candidate against one stored circle.
`timescale 1ns / 1ps

module ncdf_cmp (
   input  ncdf_pkg::entry_type cand,
   input  ncdf_pkg::entry_type entry,
   output logic                hit
);

   ncdf_pkg::coord_type diff_x;
   ncdf_pkg::coord_type diff_y;

   always_comb begin
      diff_x = (cand.x >= entry.x) ? (cand.x - entry.x) : (entry.x - cand.x);
      diff_y = (cand.y >= entry.y) ? (cand.y - entry.y) : (entry.y - cand.y);
      // Strict test, so an entry of zero radius never matches.
      hit    = (diff_x < entry.radius) && (diff_y < entry.radius);
   end

endmodule

// ----- rtl/core/near_circle_duplicate_filter.sv -----
// A request is accepted only in idle; the scan then compares it with each stored circle of
// the current list (at most 64), and a result is offered in the respond state until taken.
// The scan reads one stored entry per cycle into the shared compare unit; a new circle is
// accepted only after the response has been taken and the block has returned to idle.
// A match ends the scan early. Reset empties the table and returns to idle; the table
// RAM itself is not cleared, only entries below the count are ever read.
`timescale 1ns / 1ps

module near_circle_duplicate_filter (
   input  logic       clock,
   input  logic       reset,
   ncdf_req_if.sink   req_port,
   ncdf_rsp_if.source rsp_port
);

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_RESP = 3'b100
   } state_type;

   state_type                      state_ff, state_in;
   logic [ncdf_pkg::COUNT_W-1:0]   count_ff, count_in;
   logic [ncdf_pkg::COUNT_W-1:0]   issue_ff, issue_in;
   logic                           pend_ff, pend_in;
   ncdf_pkg::entry_type            cand_ff, cand_in;
   logic                           kept_ff, kept_in;
   logic                           full_ff, full_in;

   logic                           rd_en;
   logic                           wr_en;
   ncdf_pkg::entry_type            rd_entry;
   logic                           hit;

   ncdf_ram #(
      .WIDTH (ncdf_pkg::ENTRY_W),
      .DEPTH (ncdf_pkg::MAX_KEPT)
   ) u_table (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[ncdf_pkg::ADDR_W-1:0]),
      .wr_data (cand_ff),
      .rd_en   (rd_en),
      .rd_addr (issue_ff[ncdf_pkg::ADDR_W-1:0]),
      .rd_data (rd_entry)
   );

   ncdf_cmp u_cmp (
      .cand  (cand_ff),
      .entry (rd_entry),
      .hit   (hit)
   );

   // A read is issued every scan cycle until all stored entries have been requested;
   // pend_ff marks that the RAM output holds an entry to be compared this cycle.
   assign rd_en = (state_ff == ST_SCAN) && (issue_ff != count_ff);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      issue_in = issue_ff;
      pend_in  = pend_ff;
      cand_in  = cand_ff;
      kept_in  = kept_ff;
      full_in  = full_ff;
      wr_en    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            pend_in = 1'b0;
            if (req_port.valid) begin
               cand_in.x      = req_port.center_x;
               cand_in.y      = req_port.center_y;
               cand_in.radius = req_port.radius;
               if (req_port.starts_list) begin
                  count_in = '0;
               end
               issue_in = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            pend_in = rd_en;
            if (rd_en) begin
               issue_in = issue_ff + ncdf_pkg::COUNT_W'(1);
            end
            if (pend_ff && hit) begin
               kept_in  = 1'b0;
               full_in  = 1'b0;
               state_in = ST_RESP;
            end else if (!rd_en && !pend_ff) begin
               kept_in = 1'b1;
               if (count_ff == ncdf_pkg::COUNT_W'(ncdf_pkg::MAX_KEPT)) begin
                  full_in = 1'b1;
               end else begin
                  full_in  = 1'b0;
                  wr_en    = 1'b1;
                  count_in = count_ff + ncdf_pkg::COUNT_W'(1);
               end
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            pend_in = 1'b0;
            if (rsp_port.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
            pend_in  = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         pend_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      issue_ff <= issue_in;
      cand_ff  <= cand_in;
      kept_ff  <= kept_in;
      full_ff  <= full_in;
   end

   assign req_port.ready      = (state_ff == ST_IDLE);
   assign rsp_port.valid      = (state_ff == ST_RESP);
   assign rsp_port.kept       = kept_ff;
   assign rsp_port.kept_index = ncdf_pkg::KEPT_INDEX_W'(count_ff);
   assign rsp_port.table_full = full_ff;

endmodule
